// File: rtl/core/pmm_pkg.sv
// shared constants, prime table and rotate helper for the multiplicative mixer
// no dependencies; used by pmm_round and prime_multiply_mix64

package pmm_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int NUM_ROUNDS = 64;
    localparam int SRC_ROT    = 13;
    localparam int TAB_DEPTH  = 2 * NUM_ROUNDS;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [HALF_W-1:0] t_half;

    // two candidate primes per round, odd entry taken when the source bit is set
    localparam t_word PRIME_TAB [TAB_DEPTH] = '{
        64'd2985113428254948959, 64'd2133371973447287789, 64'd9566925003104080411,
        64'd6083414080430737261, 64'd3191658566037706763, 64'd6913367267901031997,
        64'd3051762490125913007, 64'd4496279044463191703, 64'd2879325911889076339,
        64'd1685450054146532617, 64'd3665492224534333199, 64'd5457405118009752311,
        64'd9603674174905975319, 64'd5115570615370213399, 64'd2085406057152991381,
        64'd3944123521248288751, 64'd7068318273059084621, 64'd9757209530458778617,
        64'd4605875306346355289, 64'd6173263078309968247, 64'd7762991333463966857,
        64'd9020426977113888977, 64'd7479023155365493211, 64'd1106308364738794853,
        64'd6407388572493574733, 64'd2575377960084637447, 64'd3570804859728957167,
        64'd9744215084471400349, 64'd5786617550671126231, 64'd3349473746601511027,
        64'd4095923646587284861, 64'd9337574612835542873, 64'd3860411135543820653,
        64'd6490253556739218821, 64'd8764900392399904901, 64'd3339372363887497583,
        64'd6577701767928311429, 64'd9172672799009443051, 64'd2788564470716716463,
        64'd7776210437768060567, 64'd9071396938031495159, 64'd5357072389526583433,
        64'd6633238451589839561, 64'd6234713344370965483, 64'd1756087432259377561,
        64'd3210111471103586737, 64'd2408295824875360559, 64'd8027800137025286071,
        64'd1345382896972678691, 64'd9079595888451204607, 64'd6556450002823963531,
        64'd7301373103704944939, 64'd1213337252585919101, 64'd8574942160927332881,
        64'd8566185364500201241, 64'd6910045784078487233, 64'd2298581249625702883,
        64'd2596136803677419831, 64'd8990581036371057601, 64'd3046889204803159003,
        64'd6864701819024214703, 64'd9142639517683050829, 64'd3257525145999184439,
        64'd5916350576516314903, 64'd1991008946812235681, 64'd5221054210441722691,
        64'd4658950185140640559, 64'd7616154792906075869, 64'd3789735489826889479,
        64'd6040491638497194979, 64'd4531551599015040559, 64'd8347022247974757701,
        64'd5867558032219360441, 64'd4346307676337591453, 64'd1905346606445378533,
        64'd7219759323757378847, 64'd8561163821217102983, 64'd6227762971465314193,
        64'd1778354250598502561, 64'd5435722899178511549, 64'd7859180386742822047,
        64'd3610133528213982527, 64'd4577787558750808879, 64'd3974497005134013109,
        64'd3241288686894948329, 64'd3206546850542044487, 64'd2621128575668534623,
        64'd6945339563322422683, 64'd2086055779082649859, 64'd9237096783908108657,
        64'd1916568609042647407, 64'd8362781431934621017, 64'd6122543372115730003,
        64'd6200399818195771541, 64'd1259180073496439959, 64'd4347405785030416513,
        64'd4385862544209720253, 64'd5836562284002027449, 64'd3121678407354608831,
        64'd4319136453194505203, 64'd9085838656424873461, 64'd5448516463713100871,
        64'd4520015808866767003, 64'd2892328915328607301, 64'd3897908110284010777,
        64'd6252018905800065119, 64'd3278710975885668139, 64'd2623408458547857527,
        64'd3055342605008846819, 64'd5255646576194862401, 64'd5611094629836787733,
        64'd3296996236992951511, 64'd3283558997806116761, 64'd2823396471863459119,
        64'd9572308265712226037, 64'd8290430615658140401, 64'd2621246478142939039,
        64'd1300291691995934101, 64'd1143863624227711889, 64'd6789671898597272039,
        64'd1593529243588418053, 64'd6573565795099723367, 64'd7154224095543629129,
        64'd2355509713379653547, 64'd7691022839137400143, 64'd2727794217173953619,
        64'd8541344794240933387, 64'd6490328854741497349
    };

    // rotate left; amount is a constant at every use, so this is wiring
    function automatic t_word rotl(input t_word v, input int unsigned n);
        logic [2*WORD_W-1:0] d;
        d = {v, v} << (n % WORD_W);
        return d[2*WORD_W-1:WORD_W];
    endfunction

endpackage

// File: rtl/core/pmm_round.sv
// one mixing round: partial products stage, then product reduce stage
// depends on pmm_pkg for the prime table and rotate helper

module pmm_round #(
    parameter int ROUND = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  pmm_pkg::t_word       i_prod,
    input  pmm_pkg::t_word       i_snk,
    input  pmm_pkg::t_word       i_src,
    output logic                 o_valid,
    output pmm_pkg::t_word       o_prod,
    output pmm_pkg::t_word       o_snk,
    output pmm_pkg::t_word       o_src
);
    import pmm_pkg::*;

    localparam int    ROT_CUR    = (SRC_ROT * (ROUND + 1)) % WORD_W;
    localparam int    ROT_PREV   = (SRC_ROT * ROUND) % WORD_W;
    localparam t_word PRIME_EVEN = PRIME_TAB[2 * ROUND];
    localparam t_word PRIME_ODD  = PRIME_TAB[2 * ROUND + 1];
    localparam logic  ADD_PREV   = (ROUND != 0);

    t_word src_cur;
    t_word src_prev;
    t_word mul_a;
    t_word mul_b;
    t_word n_ll;
    t_half n_lh;
    t_half n_hl;
    t_word n_m_snk;

    logic  r_m_valid;
    t_word r_ll;
    t_half r_lh;
    t_half r_hl;
    t_word r_m_snk;
    t_word r_m_src;

    t_half cross_sum;
    t_word n_prod;

    logic  r_a_valid;
    t_word r_prod;
    t_word r_snk;
    t_word r_src;

    // source rotation stays implicit: the original word travels, taps are fixed wiring
    assign src_cur  = rotl(i_src, ROT_CUR);
    assign src_prev = rotl(i_src, ROT_PREV);
    assign mul_a    = rotl(i_prod, ROUND);
    assign mul_b    = src_cur[0] ? PRIME_ODD : PRIME_EVEN;

    // low 64 bits of the product from three 32x32 partials
    assign n_ll = mul_a[HALF_W-1:0] * mul_b[HALF_W-1:0];
    assign n_lh = mul_a[HALF_W-1:0] * mul_b[WORD_W-1:HALF_W];
    assign n_hl = mul_a[WORD_W-1:HALF_W] * mul_b[HALF_W-1:0];

    // previous round's sink contribution is added here, alongside the multiply
    assign n_m_snk = i_snk + (ADD_PREV ? (i_prod ^ src_prev) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
        end
        r_ll    <= n_ll;
        r_lh    <= n_lh;
        r_hl    <= n_hl;
        r_m_snk <= n_m_snk;
        r_m_src <= i_src;
    end

    assign cross_sum = r_lh + r_hl;
    assign n_prod    = r_ll + {cross_sum, {HALF_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= r_m_valid;
        end
        r_prod <= n_prod;
        r_snk  <= r_m_snk;
        r_src  <= r_m_src;
    end

    assign o_valid = r_a_valid;
    assign o_prod  = r_prod;
    assign o_snk   = r_snk;
    assign o_src   = r_src;

`ifndef ASSERT_OFF
    a_snk_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_m_valid) |-> (r_snk == $past(r_m_snk)))
        else $error("sink word corrupted in round");

    a_valid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_a_valid == $past(r_m_valid)))
        else $error("valid bit dropped or invented between round stages");

    a_src_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_m_valid) |-> (r_src == $past(r_m_src)))
        else $error("source word corrupted in round");
`endif

endmodule

// File: rtl/core/prime_multiply_mix64.sv
// top level of the 64-round multiplicative mixer: round pipeline plus final fold
// depends on pmm_pkg and pmm_round

// A request is taken on every clock in which start is high and busy is low; busy
// is high only while reset is held, so one word pair can enter each cycle. Each
// request gives exactly one new_sink, shown for one cycle with o_strobe, after
// two register stages per round (partial products, then product reduce) over
// 64 rounds, plus one output stage for the last sink add and fold. Results
// leave in request order and cannot be held off.

module prime_multiply_mix64 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pmm_pkg::t_word       i_source_word,
    input  pmm_pkg::t_word       i_sink_word,
    output logic                 o_strobe,
    output pmm_pkg::t_word       o_new_sink
);
    import pmm_pkg::*;

    logic  stg_valid [NUM_ROUNDS+1];
    t_word stg_prod  [NUM_ROUNDS+1];
    t_word stg_snk   [NUM_ROUNDS+1];
    t_word stg_src   [NUM_ROUNDS+1];

    logic  r_out_valid;
    t_word r_new_sink;
    t_word n_new_sink;

    assign busy = ~i_rst_n;

    assign stg_valid[0] = start & ~busy;
    assign stg_prod[0]  = t_word'(1);
    assign stg_snk[0]   = i_sink_word;
    assign stg_src[0]   = i_source_word;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        pmm_round #(
            .ROUND (g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .i_prod  (stg_prod[g]),
            .i_snk   (stg_snk[g]),
            .i_src   (stg_src[g]),
            .o_valid (stg_valid[g+1]),
            .o_prod  (stg_prod[g+1]),
            .o_snk   (stg_snk[g+1]),
            .o_src   (stg_src[g+1])
        );
    end

    // last round's source rotation is a full turn, so the plain source is used
    assign n_new_sink = (stg_snk[NUM_ROUNDS] + (stg_prod[NUM_ROUNDS] ^ stg_src[NUM_ROUNDS]))
                        ^ stg_prod[NUM_ROUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= stg_valid[NUM_ROUNDS];
        end
        r_new_sink <= n_new_sink;
    end

    assign o_strobe   = r_out_valid;
    assign o_new_sink = r_new_sink;

`ifndef ASSERT_OFF
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_strobe == $past(stg_valid[NUM_ROUNDS])))
        else $error("result strobe does not match last round valid");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(stg_valid[NUM_ROUNDS]) |-> (o_new_sink == $past(n_new_sink)))
        else $error("result word does not match final fold");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised outside reset");
`endif

endmodule
